// ===== hw/rtl/retransmit_timer_rtt_estimator_unit_macros.svh =====
// Assertion helpers for the checker in rtte_checker.sv.
`ifndef RETRANSMIT_TIMER_RTT_ESTIMATOR_UNIT_MACROS_SVH
`define RETRANSMIT_TIMER_RTT_ESTIMATOR_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RTTE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rtte check failed");

// When the trigger holds, the consequence must hold at the next edge.
`define RTTE_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("rtte check failed");

`endif

// ===== hw/rtl/rtte_pkg.sv =====
package rtte_pkg;

  typedef enum logic [1:0] {
    ModeNone   = 2'd0,
    ModeLinear = 2'd1,
    ModeExp    = 2'd2
  } backoff_mode_e;

  typedef enum logic [1:0] {
    RegBackoffMode = 2'd0,
    RegClampLow    = 2'd1,
    RegClampHigh   = 2'd2
  } cfg_reg_e;

  localparam int unsigned TicksW = 16;
  localparam int unsigned RetryW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam backoff_mode_e ModeResetValue = ModeLinear;
  localparam logic [TicksW-1:0] ClampLowReset  = 16'd10;
  localparam logic [TicksW-1:0] ClampHighReset = 16'd300;
  localparam logic [TicksW-1:0] RttResetValue  = 16'd10;
  localparam logic [TicksW-1:0] TicksMax       = 16'hFFFF;

  // The weighted sum 9*rtt + cur stays below 2^20; ceil(2^24/10) divides it
  // exactly by ten after a shift by 24.
  localparam int unsigned SumW      = 20;
  localparam int unsigned DivShift  = 24;
  localparam int unsigned DivMultW  = 21;
  localparam logic [DivMultW-1:0] DivTenMult = 21'd1677722;

  typedef struct packed {
    backoff_mode_e     mode;
    logic [TicksW-1:0] clamp_low;
    logic [TicksW-1:0] clamp_high;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [RetryW-1:0] retry_count;
    logic [TicksW-1:0] timeout_current;
    logic [TicksW-1:0] timeout_remaining;
  } req_t;

endpackage

// ===== hw/rtl/rtte_calc.sv =====
module rtte_calc (
  input  rtte_pkg::cfg_t                   cfg_i,
  input  rtte_pkg::req_t                   req_i,
  input  logic [rtte_pkg::TicksW-1:0]      rtt_i,
  output logic [rtte_pkg::TicksW-1:0]      timeout_value_o,
  output logic [rtte_pkg::TicksW-1:0]      rtt_next_o
);
  import rtte_pkg::*;

  logic [SumW-1:0]             pos_sum;
  logic signed [SumW:0]        sum;
  logic [SumW+DivMultW-1:0]    div_prod;
  logic [TicksW-1:0]           avg;
  logic [TicksW-1:0]           est;
  logic                        est_below;
  logic [TicksW-1:0]           est_low;
  logic [6:0]                  factor;
  logic [TicksW+6:0]           tmo_prod;

  always_comb begin
    pos_sum  = {1'b0, rtt_i, 3'b000} + {4'b0, rtt_i} + {4'b0, req_i.timeout_current};
    sum      = $signed({1'b0, pos_sum}) - $signed({5'b0, req_i.timeout_remaining});
    div_prod = sum[SumW-1:0] * DivTenMult;
    avg      = div_prod[DivShift +: TicksW];

    est       = rtt_i;
    est_below = 1'b0;
    case (cfg_i.mode)
      ModeNone: begin
        est = {1'b0, req_i.timeout_current[TicksW-1:1]};
      end
      ModeLinear, ModeExp: begin
        if (req_i.timeout_remaining != '0 && req_i.retry_count == '0) begin
          // A negative sum lands at or below zero, so it always takes the low bound.
          est       = avg;
          est_below = sum[SumW];
        end
      end
      default: begin
        est = rtt_i;
      end
    endcase

    est_low = (est_below || est < cfg_i.clamp_low) ? cfg_i.clamp_low : est;

    factor = 7'd2;
    case (cfg_i.mode)
      ModeLinear: factor = {1'b0, req_i.retry_count, 1'b0} + 7'd2;
      ModeExp: begin
        if (req_i.retry_count == 5'd0) begin
          factor = 7'd2;
        end else if (req_i.retry_count == 5'd1) begin
          factor = 7'd4;
        end else begin
          factor = 7'd8;
        end
      end
      default: factor = 7'd2;
    endcase
    tmo_prod = factor * rtt_i;

    if (req_i.func) begin
      rtt_next_o      = rtt_i;
      timeout_value_o = (tmo_prod[TicksW+6:TicksW] != '0) ? TicksMax
                                                           : tmo_prod[TicksW-1:0];
    end else begin
      rtt_next_o      = (est_low > cfg_i.clamp_high) ? cfg_i.clamp_high : est_low;
      timeout_value_o = '0;
    end
  end

endmodule

// ===== hw/rtl/retransmit_timer_rtt_estimator_unit.sv =====
// Each input transfer is captured in the input register and then moves to the result
// register, where it is held while the output is stalled.
// Throughput: one item per cycle unless the output stalls; the estimate register is read
// and rewritten in the same cycle, so consecutive updates chain without a bubble.
// Reset: pipeline empty, backoff mode 1, bounds 10 and 300, estimate 10.
module retransmit_timer_rtt_estimator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtte_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rtte_pkg::TicksW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [rtte_pkg::RetryW-1:0]         retry_count_i,
  input  logic [rtte_pkg::TicksW-1:0]         timeout_current_i,
  input  logic [rtte_pkg::TicksW-1:0]         timeout_remaining_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rtte_pkg::TicksW-1:0]         timeout_value_o,
  output logic [rtte_pkg::TicksW-1:0]         rtt_value_o
);
  import rtte_pkg::*;

  cfg_t              cfg_q;
  req_t              req_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic [TicksW-1:0] rtt_q;
  logic [TicksW-1:0] tmo_q;
  logic [TicksW-1:0] rtt_out_q;
  logic [TicksW-1:0] tmo_d;
  logic [TicksW-1:0] rtt_d;
  logic              out_free;
  logic              advance;
  logic              in_xfer;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= ModeResetValue;
      cfg_q.clamp_low  <= ClampLowReset;
      cfg_q.clamp_high <= ClampHighReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBackoffMode: cfg_q.mode       <= backoff_mode_e'(cfg_wdata_i[1:0]);
        RegClampLow:    cfg_q.clamp_low  <= cfg_wdata_i;
        RegClampHigh:   cfg_q.clamp_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rtt_q     <= RttResetValue;
    end else begin
      if (!in_vld_q || out_free) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        rtt_q <= rtt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.func              <= func_i;
      req_q.retry_count       <= retry_count_i;
      req_q.timeout_current   <= timeout_current_i;
      req_q.timeout_remaining <= timeout_remaining_i;
    end
    if (advance) begin
      tmo_q     <= tmo_d;
      rtt_out_q <= rtt_d;
    end
  end

  rtte_calc u_calc (
    .cfg_i           (cfg_q),
    .req_i           (req_q),
    .rtt_i           (rtt_q),
    .timeout_value_o (tmo_d),
    .rtt_next_o      (rtt_d)
  );

  assign out_valid_o     = out_vld_q;
  assign timeout_value_o = tmo_q;
  assign rtt_value_o     = rtt_out_q;

endmodule

// ===== hw/rtl/rtte_checker.sv =====
`include "retransmit_timer_rtt_estimator_unit_macros.svh"

module rtte_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [rtte_pkg::TicksW-1:0]    timeout_value_o,
  input logic [rtte_pkg::TicksW-1:0]    rtt_value_o
);
  import rtte_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  // A stalled result holds still.
  `RTTE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(timeout_value_o) && $stable(rtt_value_o))

  // With the output register empty the input side never stalls.
  `RTTE_ASSERT(a_no_stall_when_empty, out_valid_o || !in_stall_o)

  // A fresh result traces back to an input transfer through the input register.
  `RTTE_ASSERT(a_rise_has_source, !$rose(out_valid_o) || $past(in_valid_i && !in_stall_o, 2))

  // A timeout result is at least twice the estimate, or saturated, so never below it.
  `RTTE_ASSERT(a_tmo_covers_rtt, !out_valid_o || timeout_value_o == '0 || timeout_value_o >= rtt_value_o)

  // A timeout request leaves the estimate as the previous result showed it.
  `RTTE_ASSERT_NEXT(a_tmo_keeps_rtt, out_xfer, !(out_xfer && timeout_value_o != '0) || rtt_value_o == $past(rtt_value_o))

endmodule

bind retransmit_timer_rtt_estimator_unit rtte_checker u_rtte_checker (.*);

// ===== tb/retransmit_timer_rtt_estimator_unit_tb.sv =====
`timescale 1ns / 100ps

module retransmit_timer_rtt_estimator_unit_tb;
  import rtte_pkg::*;

  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncTimeout = 1'b1;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int SettleCycles = 4;
  localparam int PhaseCount = 8;
  localparam int ItemsPerPhase = 69;
  localparam int SendIdleSeq [4] = '{0, 65, 0, 33};
  localparam int StallSeq [4] = '{0, 0, 65, 33};
  localparam logic [1:0] ModeSeq [PhaseCount] = '{ModeLinear, ModeExp, ModeNone, ModeExp,
                                                  ModeLinear, ModeUnused, ModeExp, ModeLinear};

  typedef struct packed {
    logic [TicksW-1:0] timeout_ticks;
    logic [TicksW-1:0] rtt_ticks;
  } rto_result_t;

  // Tracks the round trip estimate and the register settings, and holds the
  // timeout and estimate that each accepted request should produce.
  class rtt_rto_tracker;
    logic [1:0]        mode;
    logic [TicksW-1:0] clamp_low;
    logic [TicksW-1:0] clamp_high;
    logic [TicksW-1:0] estimate;
    rto_result_t       awaited[$];
    int                error_count;

    function new();
      mode = ModeResetValue;
      clamp_low = ClampLowReset;
      clamp_high = ClampHighReset;
      estimate = RttResetValue;
      error_count = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] data);
      case (idx)
        RegBackoffMode: mode = data[1:0];
        RegClampLow:    clamp_low = data;
        RegClampHigh:   clamp_high = data;
        default: ;
      endcase
    endfunction

    function void note_request(logic func, logic [RetryW-1:0] retries,
                               logic [TicksW-1:0] cur, logic [TicksW-1:0] rem);
      int          est;
      int          weighted;
      int unsigned factor;
      int unsigned product;
      rto_result_t res;
      res.timeout_ticks = '0;
      if (func == FuncUpdate) begin
        est = int'(estimate);
        if (mode == ModeNone) begin
          est = int'(cur >> 1);
        end else if ((mode == ModeLinear || mode == ModeExp) && rem != 0 && retries == 0) begin
          // Signed division truncates toward zero, so small negative sums give zero.
          weighted = 9 * int'(estimate) + int'(cur) - int'(rem);
          est = weighted / 10;
        end
        if (est < int'(clamp_low)) est = int'(clamp_low);
        if (est > int'(clamp_high)) est = int'(clamp_high);
        estimate = est[TicksW-1:0];
      end else begin
        case (mode)
          ModeLinear: factor = 2 + 2 * int'(retries);
          ModeExp:    factor = (retries == 0) ? 2 : ((retries == 1) ? 4 : 8);
          default:    factor = 2;
        endcase
        product = factor * int'(estimate);
        res.timeout_ticks = (product > TicksMax) ? TicksMax : product[TicksW-1:0];
      end
      res.rtt_ticks = estimate;
      awaited.push_back(res);
    endfunction

    function void check_result(logic [TicksW-1:0] timeout_val, logic [TicksW-1:0] rtt_val);
      rto_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: timeout_value %0d rtt_value %0d", timeout_val, rtt_val);
        error_count++;
        return;
      end
      want = awaited.pop_front();
      if (timeout_val !== want.timeout_ticks) begin
        $error("timeout_value: expected %0d, actual %0d", want.timeout_ticks, timeout_val);
        error_count++;
      end
      if (rtt_val !== want.rtt_ticks) begin
        $error("rtt_value: expected %0d, actual %0d", want.rtt_ticks, rtt_val);
        error_count++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [TicksW-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  logic [RetryW-1:0]    retry_count_i;
  logic [TicksW-1:0]    timeout_current_i;
  logic [TicksW-1:0]    timeout_remaining_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [TicksW-1:0]    timeout_value_o;
  logic [TicksW-1:0]    rtt_value_o;

  int send_idle_pct = 0;
  int out_stall_pct = 0;
  rtt_rto_tracker tracker;

  retransmit_timer_rtt_estimator_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .retry_count_i      (retry_count_i),
    .timeout_current_i  (timeout_current_i),
    .timeout_remaining_i(timeout_remaining_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .timeout_value_o    (timeout_value_o),
    .rtt_value_o        (rtt_value_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.note_request(func_i, retry_count_i, timeout_current_i, timeout_remaining_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result(timeout_value_o, rtt_value_o);
      end
    end
  end

  // Valid stays high from one transfer to the next unless an idle cycle is drawn.
  task automatic send_request(input logic func, input logic [RetryW-1:0] retries,
                              input logic [TicksW-1:0] cur, input logic [TicksW-1:0] rem);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    retry_count_i <= retries;
    timeout_current_i <= cur;
    timeout_remaining_i <= rem;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TicksW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.write_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly plausible acks with the retry count at zero, so that the estimate
  // actually moves; the rest is unconstrained noise.
  task automatic random_request();
    logic              func;
    logic [RetryW-1:0] retries;
    logic [TicksW-1:0] cur;
    logic [TicksW-1:0] rem;
    func = 1'($urandom_range(1));
    if ($urandom_range(99) < 55) retries = '0;
    else retries = RetryW'($urandom_range(31));
    case ($urandom_range(9))
      0, 1: begin
        cur = TicksW'($urandom);
        rem = TicksW'($urandom);
      end
      2: begin
        cur = TicksW'($urandom_range(15));
        rem = TicksW'($urandom_range(15));
      end
      3: begin
        cur = TicksW'($urandom_range(65535, 30000));
        rem = TicksW'($urandom_range(cur, 1));
      end
      4: begin
        cur = TicksW'($urandom_range(4000));
        rem = '0;
      end
      default: begin
        cur = TicksW'($urandom_range(4000, 1));
        rem = TicksW'($urandom_range(cur, 1));
      end
    endcase
    send_request(func, retries, cur, rem);
  endtask

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [TicksW-1:0] wdata;
    logic [TicksW-1:0] low_bound;
    logic [TicksW-1:0] high_bound;
    int                sel;
    tracker = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    func_i = 1'b0;
    retry_count_i = '0;
    timeout_current_i = '0;
    timeout_remaining_i = '0;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Reset settings: linear backoff, bounds 10 and 300.
    send_request(FuncTimeout, '0, '0, '0);
    send_request(FuncTimeout, 5'd31, '0, '0);
    send_request(FuncUpdate, '0, 16'd200, 16'd50);
    send_request(FuncUpdate, 5'd1, 16'd200, 16'd50);
    send_request(FuncUpdate, '0, 16'd200, '0);
    send_request(FuncUpdate, '0, '0, TicksMax);
    send_request(FuncUpdate, '0, TicksMax, 16'd1);
    drain();
    write_reg(RegUnused, TicksMax);
    write_reg(RegBackoffMode, 16'hFFFC);
    write_reg(RegClampLow, '0);
    write_reg(RegClampHigh, TicksMax);
    // The new bounds must not touch the stored estimate before the next update.
    send_request(FuncTimeout, '0, '0, '0);
    send_request(FuncUpdate, 5'd31, TicksMax, TicksMax);
    send_request(FuncTimeout, 5'd5, '0, '0);
    send_request(FuncUpdate, '0, 16'd1, '0);
    drain();
    write_reg(RegBackoffMode, ModeExp);
    send_request(FuncUpdate, '0, '0, 16'd5);
    send_request(FuncUpdate, '0, TicksMax, 16'd1);
    send_request(FuncTimeout, 5'd0, '0, '0);
    send_request(FuncTimeout, 5'd1, '0, '0);
    send_request(FuncTimeout, 5'd2, '0, '0);
    send_request(FuncTimeout, 5'd31, '0, '0);
    drain();
    write_reg(RegBackoffMode, ModeNone);
    send_request(FuncUpdate, '0, TicksMax, '0);
    drain();
    write_reg(RegBackoffMode, ModeExp);
    send_request(FuncTimeout, 5'd3, '0, '0);
    drain();
    write_reg(RegBackoffMode, ModeLinear);
    send_request(FuncTimeout, 5'd31, '0, '0);
    drain();
    // Unused mode with crossed bounds: the high bound wins.
    write_reg(RegBackoffMode, ModeUnused);
    write_reg(RegClampLow, 16'd500);
    write_reg(RegClampHigh, 16'd100);
    send_request(FuncUpdate, '0, 16'd1000, 16'd1);
    send_request(FuncTimeout, 5'd31, '0, '0);

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      send_idle_pct = SendIdleSeq[p % 4];
      out_stall_pct = StallSeq[p % 4];
      wdata = TicksW'($urandom);
      wdata[1:0] = ModeSeq[p];
      write_reg(RegBackoffMode, wdata);
      sel = (p == 0) ? 0 : $urandom_range(3);
      case (sel)
        0: begin
          low_bound = '0;
          high_bound = TicksMax;
        end
        1: begin
          low_bound = TicksW'($urandom_range(100));
          high_bound = TicksW'($urandom_range(5000, 200));
        end
        2: begin
          low_bound = TicksW'($urandom);
          high_bound = TicksW'($urandom);
        end
        default: begin
          low_bound = TicksMax;
          high_bound = TicksMax;
        end
      endcase
      write_reg(RegClampLow, low_bound);
      write_reg(RegClampHigh, high_bound);
      if ($urandom_range(3) == 0) write_reg(RegUnused, TicksW'($urandom));
      repeat (ItemsPerPhase) random_request();
    end
    drain();

    if (tracker.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rtte_pkg.sv
hw/rtl/rtte_calc.sv
hw/rtl/retransmit_timer_rtt_estimator_unit.sv
hw/rtl/rtte_checker.sv
tb/retransmit_timer_rtt_estimator_unit_tb.sv
